FILE: rtl/core/rmsvc_pkg.sv
// rms voltage compliance types, constants and microcode rom
`timescale 1ns / 1ps

package rmsvc_pkg;

    // fixed field and datapath widths
    localparam int VOLT_W    = 16;
    localparam int SQ_W      = 32;
    localparam int SUM_W     = 48;
    localparam int RMS_W     = 16;
    localparam int LIMIT_W   = 15;
    localparam int SEL_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PC_W      = 3;
    localparam int ITER_W    = 6;

    // reset values of the limit registers (207 V and 253 V at 1/64 V)
    localparam logic [LIMIT_W-1:0] LIMIT_LOW_RST  = 15'd13248;
    localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RST = 15'd16192;

    // phase selector codes
    typedef enum logic [SEL_W-1:0] {
        PHASE_A    = 2'd0,
        PHASE_B    = 2'd1,
        PHASE_C    = 2'd2,
        PHASE_NONE = 2'd3
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_SELECT = 2'd0,
        REG_LIMIT_LOW    = 2'd1,
        REG_LIMIT_HIGH   = 2'd2
    } cfg_reg_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_TAKE      = 3'd1,
        OP_ACCUM     = 3'd2,
        OP_DIV_INIT  = 3'd3,
        OP_DIV_STEP  = 3'd4,
        OP_SQRT_INIT = 3'd5,
        OP_SQRT_STEP = 3'd6,
        OP_RESULT    = 3'd7
    } op_t;

    // jump conditions; when false the step counter advances by one unless stalled
    typedef enum logic [1:0] {
        COND_NEXT     = 2'd0,
        COND_ALWAYS   = 2'd1,
        COND_NOT_LAST = 2'd2,
        COND_LOOP     = 2'd3
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [PC_W-1:0]   target;
        logic [ITER_W-1:0] loop_last;
    } ctrl_word_t;

    // step addresses
    localparam logic [PC_W-1:0] STEP_TAKE      = 3'd0;
    localparam logic [PC_W-1:0] STEP_ACCUM     = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIV_INIT  = 3'd2;
    localparam logic [PC_W-1:0] STEP_DIV_STEP  = 3'd3;
    localparam logic [PC_W-1:0] STEP_SQRT_INIT = 3'd4;
    localparam logic [PC_W-1:0] STEP_SQRT_STEP = 3'd5;
    localparam logic [PC_W-1:0] STEP_RESULT    = 3'd6;

    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(SUM_W - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(RMS_W - 1);

    // microcode program
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_TAKE, loop_last: '0};
        case (pc)
            STEP_TAKE:
                cw = '{op: OP_TAKE, cond: COND_NEXT, target: STEP_TAKE, loop_last: '0};
            STEP_ACCUM:
                cw = '{op: OP_ACCUM, cond: COND_NOT_LAST, target: STEP_TAKE,
                       loop_last: '0};
            STEP_DIV_INIT:
                cw = '{op: OP_DIV_INIT, cond: COND_NEXT, target: STEP_TAKE,
                       loop_last: '0};
            STEP_DIV_STEP:
                cw = '{op: OP_DIV_STEP, cond: COND_LOOP, target: STEP_DIV_STEP,
                       loop_last: DIV_LAST};
            STEP_SQRT_INIT:
                cw = '{op: OP_SQRT_INIT, cond: COND_NEXT, target: STEP_TAKE,
                       loop_last: '0};
            STEP_SQRT_STEP:
                cw = '{op: OP_SQRT_STEP, cond: COND_LOOP, target: STEP_SQRT_STEP,
                       loop_last: SQRT_LAST};
            STEP_RESULT:
                cw = '{op: OP_RESULT, cond: COND_ALWAYS, target: STEP_TAKE,
                       loop_last: '0};
            default:
                cw = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_TAKE, loop_last: '0};
        endcase
        return cw;
    endfunction

endpackage

FILE: rtl/core/rms_voltage_compliance_top.sv
// rms voltage compliance meter: microcoded accumulate, divide and square root
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata = volt_a, volt_b, volt_c; s_tlast = last
//  m_*      out  m_tvalid / m_tready  m_tdata = rms; m_tuser = compliant
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  a sample not marked last goes through take (with the square) and accumulate
//  a last sample goes on through divide setup, 48 restoring divide steps,
//  root setup, 16 root steps and the result load, set by the shared step counter
//  the result load waits while the output register holds an untaken beat
//  reset clears the step counter, sum, sample count and output valid and loads the limit and phase defaults
`timescale 1ns / 1ps

module rms_voltage_compliance_top #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // volt_a [15:0], volt_b [31:16], volt_c [47:32]
    input  logic [3*rmsvc_pkg::VOLT_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rms [15:0]
    output logic [rmsvc_pkg::RMS_W-1:0]         m_tdata,
    // compliant [0]
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rmsvc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmsvc_pkg::LIMIT_W-1:0]       cfg_data
);
    import rmsvc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    // sequencer
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    ctrl_word_t        cw;
    logic              stall;
    logic              jump;

    // configuration
    phase_t              phase_sel_reg;
    logic [LIMIT_W-1:0]  limit_low_reg, limit_high_reg;

    // accumulation
    logic signed [VOLT_W-1:0] volt_sel;
    logic signed [SQ_W-1:0]   volt_ext;
    logic [SQ_W-1:0]          square;
    logic [SQ_W-1:0]          sq_reg;
    logic                     last_reg;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    // divider
    logic [CNT_W-1:0]  div_reg;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    div_shift, div_diff;
    logic              div_ge;

    // square root
    logic [SQ_W-1:0]   rad_reg, rad_next;
    logic [RMS_W-1:0]  root_reg, root_next;
    logic [RMS_W:0]    srem_reg, srem_next;
    logic [RMS_W+2:0]  sq_shift, sq_trial, sq_diff;
    logic              sq_ge;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [RMS_W-1:0]  rms_reg;
    logic              comp_reg;
    logic              in_beat;
    logic              load_out;

    // control word fetch and step sequencing
    always_comb
    begin
        cw = ucode_rom(pc_reg);
        stall = ((cw.op == OP_TAKE) && !s_tvalid)
             || ((cw.op == OP_RESULT) && m_tvalid_reg && !m_tready);
        case (cw.cond)
            COND_NEXT:     jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NOT_LAST: jump = !last_reg;
            COND_LOOP:     jump = (iter_reg != cw.loop_last);
            default:       jump = 1'b0;
        endcase
        if (stall)
            pc_next = pc_reg;
        else if (jump)
            pc_next = cw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    assign s_tready = (cw.op == OP_TAKE);
    assign in_beat  = s_tvalid && s_tready;
    assign load_out = (cw.op == OP_RESULT) && !stall;

    // selected phase and its square, widened before the multiply
    always_comb
    begin
        case (phase_sel_reg)
            PHASE_A: volt_sel = s_tdata[VOLT_W-1:0];
            PHASE_B: volt_sel = s_tdata[2*VOLT_W-1:VOLT_W];
            PHASE_C: volt_sel = s_tdata[3*VOLT_W-1:2*VOLT_W];
            default: volt_sel = '0;
        endcase
        volt_ext = SQ_W'(volt_sel);
        square   = volt_ext * volt_ext;
    end

    // divider step: one quotient bit per cycle
    always_comb
    begin
        div_shift = {rem_reg, quo_reg[SUM_W-1]};
        div_diff  = div_shift - {1'b0, div_reg};
        div_ge    = (div_shift >= {1'b0, div_reg});
        rem_next  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        quo_next  = {quo_reg[SUM_W-2:0], div_ge};
    end

    // square root step: one root bit per cycle
    always_comb
    begin
        sq_shift  = {srem_reg, rad_reg[SQ_W-1 -: 2]};
        sq_trial  = {1'b0, root_reg, 2'b01};
        sq_diff   = sq_shift - sq_trial;
        sq_ge     = (sq_shift >= sq_trial);
        srem_next = sq_ge ? sq_diff[RMS_W:0] : sq_shift[RMS_W:0];
        root_next = {root_reg[RMS_W-2:0], sq_ge};
        rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
    end

    // accumulator and loop counter next values
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        iter_next  = iter_reg;
        case (cw.op)
            OP_ACCUM:
            begin
                if (count_reg < CNT_MAX)
                begin
                    sum_next   = sum_reg + SUM_W'(sq_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DIV_INIT, OP_SQRT_INIT:
            begin
                iter_next = '0;
                if (cw.op == OP_DIV_INIT)
                begin
                    sum_next   = '0;
                    count_next = '0;
                end
            end
            OP_DIV_STEP, OP_SQRT_STEP:
                iter_next = iter_reg + 1'b1;
            default:
                iter_next = iter_reg;
        endcase
    end

    // output valid
    always_comb
    begin
        if (load_out)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= STEP_TAKE;
            iter_reg       <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            phase_sel_reg  <= PHASE_A;
            limit_low_reg  <= LIMIT_LOW_RST;
            limit_high_reg <= LIMIT_HIGH_RST;
        end
        else
        begin
            pc_reg       <= pc_next;
            iter_reg     <= iter_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PHASE_SELECT: phase_sel_reg  <= phase_t'(cfg_data[SEL_W-1:0]);
                    REG_LIMIT_LOW:    limit_low_reg  <= cfg_data;
                    REG_LIMIT_HIGH:   limit_high_reg <= cfg_data;
                    default:          phase_sel_reg  <= phase_sel_reg;
                endcase
            end
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            sq_reg   <= square;
            last_reg <= s_tlast;
        end
        case (cw.op)
            OP_DIV_INIT:
            begin
                div_reg <= count_reg;
                quo_reg <= sum_reg;
                rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
            end
            OP_SQRT_INIT:
            begin
                rad_reg  <= quo_reg[SQ_W-1:0];
                root_reg <= '0;
                srem_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                rad_reg  <= rad_next;
                root_reg <= root_next;
                srem_reg <= srem_next;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
        if (load_out)
        begin
            rms_reg  <= root_reg;
            comp_reg <= (root_reg >= {1'b0, limit_low_reg})
                     && (root_reg <= {1'b0, limit_high_reg});
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = rms_reg;
    assign m_tuser   = comp_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTH
    // the sample count never passes the window limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("sample count beyond window limit");

    // the divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == OP_DIV_STEP) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // the root remainder never exceeds twice the partial root
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == OP_SQRT_STEP) |-> ({1'b0, srem_reg} <= {root_reg, 1'b0}))
        else $error("root remainder out of range");

    // a result load always presents a beat on the next cycle
    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid)
        else $error("result load without output beat");

    // input is taken only at the take step, never mid computation
    a_take_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (pc_reg == STEP_ACCUM))
        else $error("accepted beat did not move to accumulate");
`endif

endmodule
